FILE: hw/rtl/tpns_pkg.sv
// Package with shared types, constants and the controller state encoding of the sampler.
package tpns_pkg;

  localparam int unsigned MaxEntriesDefault = 1024;
  localparam int unsigned ProbW = 16;
  localparam int unsigned RandW = 16;
  localparam int unsigned ThrW = 17;
  localparam int unsigned IdxOutW = 10;
  localparam int unsigned SizeOutW = 11;
  localparam logic [ThrW-1:0] ThrReset = 17'd58982;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PASS,
    ST_SEG,
    ST_MSTEP,
    ST_MCAPI,
    ST_MCAPJ,
    ST_PRD,
    ST_PCAP,
    ST_DRD,
    ST_DCAP,
    ST_DONE
  } tpns_state_t;

  typedef struct packed {
    logic load_we;
    logic load_last;
    logic pass_start;
    logic seg_start;
    logic seg_next;
    logic swap;
    logic rd_i;
    logic rd_j;
    logic merge_wr;
    logic cap_i;
    logic cap_j;
    logic pre_start;
    logic pre_rd;
    logic pre_acc;
    logic draw_start;
    logic draw_rd;
    logic draw_acc;
  } tpns_cmd_t;

  typedef struct packed {
    logic sort_done;
    logic seg_end;
    logic pass_end;
    logic need_i;
    logic need_j;
    logic pre_done;
    logic draw_end;
    logic draw_hit;
  } tpns_stat_t;

endpackage

FILE: hw/rtl/tpns_if.sv
// Valid-ready channel interface with source and sink modports.
interface tpns_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/tpns_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tpns_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/tpns_ctrl.sv
// Controller state machine that sequences load, merge sort, prefix scan and draw.
module tpns_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 in_last,
  input  logic                 out_ready,
  output logic                 in_ready,
  output logic                 out_valid,
  output tpns_pkg::tpns_cmd_t  cmd,
  input  tpns_pkg::tpns_stat_t stat,
  output tpns_pkg::tpns_state_t state
);
  import tpns_pkg::*;

  tpns_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load_we = 1'b1;
          if (in_last) begin
            cmd.load_last = 1'b1;
            state_nxt = ST_PASS;
          end
        end
      end
      ST_PASS: begin
        if (stat.sort_done) begin
          cmd.pre_start = 1'b1;
          state_nxt = ST_PRD;
        end else begin
          cmd.pass_start = 1'b1;
          state_nxt = ST_SEG;
        end
      end
      ST_SEG: begin
        cmd.seg_start = 1'b1;
        state_nxt = ST_MSTEP;
      end
      ST_MSTEP: begin
        if (stat.seg_end) begin
          if (stat.pass_end) begin
            cmd.swap = 1'b1;
            state_nxt = ST_PASS;
          end else begin
            cmd.seg_next = 1'b1;
            state_nxt = ST_SEG;
          end
        end else if (stat.need_i) begin
          cmd.rd_i = 1'b1;
          state_nxt = ST_MCAPI;
        end else if (stat.need_j) begin
          cmd.rd_j = 1'b1;
          state_nxt = ST_MCAPJ;
        end else begin
          cmd.merge_wr = 1'b1;
        end
      end
      ST_MCAPI: begin
        cmd.cap_i = 1'b1;
        state_nxt = ST_MSTEP;
      end
      ST_MCAPJ: begin
        cmd.cap_j = 1'b1;
        state_nxt = ST_MSTEP;
      end
      ST_PRD: begin
        if (stat.pre_done) begin
          cmd.draw_start = 1'b1;
          state_nxt = ST_DRD;
        end else begin
          cmd.pre_rd = 1'b1;
          state_nxt = ST_PCAP;
        end
      end
      ST_PCAP: begin
        cmd.pre_acc = 1'b1;
        state_nxt = ST_PRD;
      end
      ST_DRD: begin
        if (stat.draw_end) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.draw_rd = 1'b1;
          state_nxt = ST_DCAP;
        end
      end
      ST_DCAP: begin
        cmd.draw_acc = 1'b1;
        if (stat.draw_hit) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DRD;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end
endmodule

FILE: hw/rtl/tpns_dp.sv
// Datapath with two sort buffers, merge heads, prefix sum and draw compare.
module tpns_dp #(
  parameter int unsigned MaxEntries = tpns_pkg::MaxEntriesDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tpns_pkg::tpns_cmd_t           cmd,
  output tpns_pkg::tpns_stat_t          stat,
  input  logic [tpns_pkg::ProbW-1:0]    in_prob,
  input  logic [tpns_pkg::RandW-1:0]    in_rand,
  input  logic [tpns_pkg::ThrW-1:0]     thr,
  output logic [tpns_pkg::IdxOutW-1:0]  chosen_index,
  output logic [tpns_pkg::SizeOutW-1:0] nucleus_size
);
  import tpns_pkg::*;

  localparam int unsigned AW = $clog2(MaxEntries);
  localparam int unsigned CW = $clog2(MaxEntries + 1);
  localparam int unsigned XW = CW + 1;
  localparam int unsigned EW = ProbW + AW;
  localparam int unsigned SW = CW + ProbW;
  localparam int unsigned PW = SW + RandW;

  logic [CW-1:0]    cnt_r, n_r, p_r, d_r;
  logic [CW-1:0]    n_nxt;
  logic [RandW-1:0] rnd_r;
  logic             src_r;
  logic [XW-1:0]    width_r, lo_r, mid_r, hi_r, i_r, j_r, k_r;
  logic [XW-1:0]    n_x, lo_w, lo_2w, mid_c, hi_c;
  logic             hv_i_r, hv_j_r;
  logic             i_ok, j_ok, take_j, load_wr;
  logic [EW-1:0]    head_i_r, head_j_r, win_word, rd_word;
  logic [ProbW-1:0] rd_prob;
  logic [AW-1:0]    rd_idx, rd_addr, last_idx_r, chosen_r;
  logic [SW-1:0]    acc_r, cdf_r, cdf_sum;
  logic [PW-1:0]    scaled_r;

  logic          o_we [2];
  logic [AW-1:0] o_wa [2];
  logic [EW-1:0] o_wd [2];
  logic [EW-1:0] o_rd [2];

  // Each buffer entry holds a probability together with its original position.
  assign n_x      = {1'b0, n_r};
  assign lo_w     = lo_r + width_r;
  assign lo_2w    = lo_r + {width_r[XW-2:0], 1'b0};
  assign mid_c    = (lo_w > n_x) ? n_x : lo_w;
  assign hi_c     = (lo_2w > n_x) ? n_x : lo_2w;
  assign i_ok     = i_r < mid_r;
  assign j_ok     = j_r < hi_r;
  assign rd_word  = o_rd[src_r];
  assign rd_prob  = rd_word[EW-1:AW];
  assign rd_idx   = rd_word[AW-1:0];
  assign take_j   = j_ok && (!i_ok || (head_j_r[EW-1:AW] > head_i_r[EW-1:AW]));
  assign win_word = take_j ? head_j_r : head_i_r;
  assign load_wr  = cmd.load_we && (cnt_r < CW'(MaxEntries));
  assign n_nxt    = load_wr ? cnt_r + CW'(1) : cnt_r;
  assign cdf_sum  = cdf_r + SW'(rd_prob);

  always_comb begin
    stat.sort_done = width_r >= n_x;
    stat.seg_end   = k_r == hi_r;
    stat.pass_end  = lo_2w >= n_x;
    stat.need_i    = i_ok && !hv_i_r;
    stat.need_j    = j_ok && !hv_j_r;
    stat.pre_done  = (acc_r > SW'(thr)) || (p_r >= n_r);
    stat.draw_end  = d_r >= p_r;
    stat.draw_hit  = scaled_r < {cdf_sum, RandW'(0)};
  end

  always_comb begin
    rd_addr = '0;
    if (cmd.rd_i) rd_addr = i_r[AW-1:0];
    else if (cmd.rd_j) rd_addr = j_r[AW-1:0];
    else if (cmd.pre_rd) rd_addr = p_r[AW-1:0];
    else if (cmd.draw_rd) rd_addr = d_r[AW-1:0];
  end

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      o_we[b] = 1'b0;
      o_wa[b] = k_r[AW-1:0];
      o_wd[b] = win_word;
    end
    if (load_wr) begin
      o_we[0] = 1'b1;
      o_wa[0] = cnt_r[AW-1:0];
      o_wd[0] = {in_prob, cnt_r[AW-1:0]};
    end else if (cmd.merge_wr) begin
      o_we[~src_r] = 1'b1;
    end
  end

  for (genvar b = 0; b < 2; b++) begin : g_ord
    tpns_ram #(.Width(EW), .Depth(MaxEntries)) u_ord (
      .clk(clk), .we(o_we[b]), .waddr(o_wa[b]), .wdata(o_wd[b]),
      .raddr(rd_addr), .rdata(o_rd[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rnd_r <= '0;
      src_r <= 1'b0;
    end else begin
      if (cmd.load_last) begin
        cnt_r <= '0;
        rnd_r <= in_rand;
      end else if (load_wr) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.load_last) src_r <= 1'b0;
      else if (cmd.swap) src_r <= ~src_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_last) n_r <= n_nxt;
    if (cmd.load_last) width_r <= XW'(1);
    else if (cmd.swap) width_r <= {width_r[XW-2:0], 1'b0};
    if (cmd.pass_start) lo_r <= '0;
    else if (cmd.seg_next) lo_r <= lo_2w;
    if (cmd.seg_start) begin
      i_r    <= lo_r;
      j_r    <= mid_c;
      k_r    <= lo_r;
      mid_r  <= mid_c;
      hi_r   <= hi_c;
      hv_i_r <= 1'b0;
      hv_j_r <= 1'b0;
    end else if (cmd.merge_wr) begin
      k_r <= k_r + XW'(1);
      if (take_j) begin
        j_r    <= j_r + XW'(1);
        hv_j_r <= 1'b0;
      end else begin
        i_r    <= i_r + XW'(1);
        hv_i_r <= 1'b0;
      end
    end else if (cmd.cap_i) begin
      head_i_r <= rd_word;
      hv_i_r   <= 1'b1;
    end else if (cmd.cap_j) begin
      head_j_r <= rd_word;
      hv_j_r   <= 1'b1;
    end
    if (cmd.pre_start) begin
      p_r   <= '0;
      acc_r <= '0;
    end else if (cmd.pre_acc) begin
      p_r        <= p_r + CW'(1);
      acc_r      <= acc_r + SW'(rd_prob);
      last_idx_r <= rd_idx;
    end
    if (cmd.draw_start) begin
      d_r      <= '0;
      cdf_r    <= '0;
      scaled_r <= PW'(rnd_r) * PW'(acc_r);
      chosen_r <= last_idx_r;
    end else if (cmd.draw_acc) begin
      d_r   <= d_r + CW'(1);
      cdf_r <= cdf_sum;
      if (stat.draw_hit) chosen_r <= rd_idx;
    end
  end

  assign chosen_index = IdxOutW'(chosen_r);
  assign nucleus_size = SizeOutW'(p_r);
endmodule

FILE: hw/rtl/top_p_nucleus_sampler_core.sv
// Top-p sampler: loads a set, merge sorts it, finds the nucleus prefix and draws one index.
// Loading accepts one beat per cycle. After the last beat, ceil(log2 n) merge passes sort the
// set, each reading run heads and writing one merged entry at a time; the prefix scan then adds
// entries until their sum exceeds the threshold, and the draw walks the kept ones to a hit.
// The result holds until taken and the next set may start on the following cycle.
// rst_n is synchronous and active low; it clears counts, fraction and state, threshold 58982.
module top_p_nucleus_sampler_core #(
  parameter int unsigned MaxEntries = tpns_pkg::MaxEntriesDefault
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tpns_pkg::ProbW-1:0]   in_probability,
  input  logic [tpns_pkg::RandW-1:0]   in_random_fraction,
  input  logic                         in_last_entry,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tpns_pkg::IdxOutW-1:0] out_chosen_index,
  output logic [tpns_pkg::SizeOutW-1:0] out_nucleus_size,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tpns_pkg::ThrW-1:0]    cfg_top_p_threshold
);
  import tpns_pkg::*;

  tpns_cmd_t   cmd;
  tpns_stat_t  stat;
  tpns_state_t state;
  logic [ThrW-1:0] thr_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ThrReset;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_top_p_threshold;
    end
  end

  tpns_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_valid && in_ready), .in_last(in_last_entry),
    .out_ready(out_ready), .in_ready(in_ready), .out_valid(out_valid),
    .cmd(cmd), .stat(stat), .state(state)
  );

  tpns_dp #(.MaxEntries(MaxEntries)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_prob(in_probability),
    .in_rand(in_random_fraction), .thr(thr_r), .chosen_index(out_chosen_index),
    .nucleus_size(out_nucleus_size)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while a result waits");
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_nucleus_size != '0) else $error("empty nucleus");
  a_load_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state == ST_LOAD) else $error("ready outside load");
endmodule

FILE: tb/top_p_nucleus_sampler_core_tb.sv
// Self-checking testbench for the top-p nucleus sampler core.
module top_p_nucleus_sampler_core_tb;
  import tpns_pkg::*;

  localparam int unsigned SetCap = MaxEntriesDefault;
  localparam int unsigned IdleLimit = 200000;
  localparam int unsigned MaxReport = 10;

  typedef struct packed {
    logic [ProbW-1:0] probability;
    logic [RandW-1:0] random_fraction;
    logic             last_entry;
  } prob_beat_t;

  typedef struct packed {
    logic [IdxOutW-1:0]  chosen_index;
    logic [SizeOutW-1:0] nucleus_size;
  } draw_beat_t;

  logic clk;
  logic rst_n;

  tpns_if #(.payload_t(prob_beat_t))      in_ch ();
  tpns_if #(.payload_t(draw_beat_t))      out_ch ();
  tpns_if #(.payload_t(logic [ThrW-1:0])) cfg_ch ();

  logic                in_ready_w;
  logic                out_valid_w;
  logic                cfg_ready_w;
  logic [IdxOutW-1:0]  out_idx_w;
  logic [SizeOutW-1:0] out_size_w;

  assign in_ch.ready  = in_ready_w;
  assign cfg_ch.ready = cfg_ready_w;
  assign out_ch.valid = out_valid_w;
  assign out_ch.data  = '{chosen_index: out_idx_w, nucleus_size: out_size_w};

  top_p_nucleus_sampler_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_ch.valid),
    .in_ready            (in_ready_w),
    .in_probability      (in_ch.data.probability),
    .in_random_fraction  (in_ch.data.random_fraction),
    .in_last_entry       (in_ch.data.last_entry),
    .out_valid           (out_valid_w),
    .out_ready           (out_ch.ready),
    .out_chosen_index    (out_idx_w),
    .out_nucleus_size    (out_size_w),
    .cfg_valid           (cfg_ch.valid),
    .cfg_ready           (cfg_ready_w),
    .cfg_top_p_threshold (cfg_ch.data)
  );

  logic [ThrW-1:0]  nucleus_limit;
  logic [ProbW-1:0] loaded_probs[$];
  draw_beat_t       pending_draws[$];
  int unsigned      mismatch_count;
  int unsigned      idle_cycles = 0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic draw_beat_t predict_draw(input logic [ProbW-1:0] probs[$],
                                              input logic [ThrW-1:0] limit,
                                              input logic [RandW-1:0] frac);
    int           rank[$];
    int           pos;
    int           kept;
    longint unsigned mass;
    longint unsigned scaled;
    longint unsigned cdf;
    draw_beat_t   res;
    for (int i = 0; i < probs.size(); i++) begin
      pos = rank.size();
      while (pos > 0 && probs[i] > probs[rank[pos-1]]) pos--;
      rank.insert(pos, i);
    end
    mass = 0;
    kept = 0;
    while (mass <= limit && kept < rank.size()) begin
      mass += probs[rank[kept]];
      kept++;
    end
    scaled = longint'(frac) * mass;
    cdf = 0;
    res.chosen_index = IdxOutW'(rank[kept-1]);
    for (int i = 0; i < kept; i++) begin
      cdf += probs[rank[i]];
      if (scaled < (cdf << 16)) begin
        res.chosen_index = IdxOutW'(rank[i]);
        break;
      end
    end
    res.nucleus_size = SizeOutW'(kept);
    return res;
  endfunction

  task automatic send_prob(input logic [ProbW-1:0] prob, input logic [RandW-1:0] frac,
                           input logic last);
    int  gap;
    logic rdy;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{probability: prob, random_fraction: frac, last_entry: last};
    do begin
      @(negedge clk);
      rdy = in_ch.ready;
      @(posedge clk);
    end while (!rdy);
    if (loaded_probs.size() < SetCap) loaded_probs = {loaded_probs, prob};
    if (last) begin
      pending_draws = {pending_draws, predict_draw(loaded_probs, nucleus_limit, frac)};
      loaded_probs.delete();
    end
  endtask

  task automatic send_set(input int count, input logic [RandW-1:0] frac, input bit skewed);
    logic [ProbW-1:0] p;
    for (int i = 0; i < count; i++) begin
      p = ProbW'($urandom);
      if (skewed && $urandom_range(0, 1)) p = ProbW'($urandom_range(0, 12000));
      send_prob(p, frac, 1'b0);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_limit(input logic [ThrW-1:0] value);
    logic rdy;
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do begin
      @(negedge clk);
      rdy = cfg_ch.ready;
      @(posedge clk);
    end while (!rdy);
    nucleus_limit = value;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_directed_sets();
    send_prob(16'd0, 16'd0, 1'b1);
    send_prob(16'hFFFF, 16'hFFFF, 1'b1);
    send_prob(16'hFFFF, 16'h0000, 1'b0);
    send_prob(16'h0000, 16'h0000, 1'b0);
    send_prob(16'hFFFF, 16'hFFFF, 1'b1);
    for (int i = 0; i < 3; i++) send_prob(16'd0, 16'h1234, 1'b0);
    send_prob(16'd0, 16'hFFFF, 1'b1);
    for (int i = 0; i < 4; i++) send_prob(16'd5000, 16'hAAAA, 1'b0);
    send_prob(16'd5000, 16'h5555, 1'b1);
    send_prob(16'h0001, 16'h0000, 1'b0);
    send_prob(16'h8000, 16'h0000, 1'b0);
    send_prob(16'h7FFF, 16'h8000, 1'b1);
  endtask

  task automatic test_limit_extremes();
    logic [ThrW-1:0] limits[5];
    limits = '{17'd0, 17'd65536, 17'd1, 17'd32768, ThrReset};
    foreach (limits[k]) begin
      write_limit(limits[k]);
      for (int s = 0; s < 4; s++) begin
        send_set($urandom_range(0, 5), RandW'($urandom), s[0]);
        send_prob(ProbW'($urandom), RandW'($urandom), 1'b1);
      end
    end
  endtask

  task automatic test_store_full();
    write_limit(ThrW'($urandom_range(0, 65536)));
    send_set(SetCap + 5, RandW'($urandom), 1'b1);
    send_prob(ProbW'($urandom), RandW'($urandom), 1'b1);
  endtask

  task automatic test_random_sets();
    int sent;
    int len;
    sent = 0;
    while (sent < 600) begin
      if ($urandom_range(0, 9) == 0) write_limit(ThrW'($urandom_range(0, 65536)));
      len = $urandom_range(0, 15);
      send_set(len, RandW'($urandom), 1'($urandom_range(0, 1)));
      send_prob(ProbW'($urandom), RandW'($urandom), 1'b1);
      sent += len + 1;
    end
  endtask

  always @(negedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_checker
    int         stall;
    logic       vld;
    draw_beat_t got;
    draw_beat_t want;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do begin
        @(negedge clk);
        vld = out_ch.valid;
        got = out_ch.data;
        @(posedge clk);
      end while (!vld);
      if (pending_draws.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReport)
          $display("Unexpected beat: index %0d size %0d", got.chosen_index, got.nucleus_size);
      end else begin
        want = pending_draws.pop_front();
        if (got.chosen_index !== want.chosen_index) begin
          mismatch_count++;
          if (mismatch_count <= MaxReport)
            $display("chosen_index: expected %0d, got %0d", want.chosen_index,
                     got.chosen_index);
        end
        if (got.nucleus_size !== want.nucleus_size) begin
          mismatch_count++;
          if (mismatch_count <= MaxReport)
            $display("nucleus_size: expected %0d, got %0d", want.nucleus_size,
                     got.nucleus_size);
        end
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.data    <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    nucleus_limit  = ThrReset;
    mismatch_count = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_sets();
    test_limit_extremes();
    test_store_full();
    test_random_sets();
    drain_results();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_draws.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
